@@ rtl/eds_pkg.sv @@
`timescale 1ns / 1ps
// eds_pkg: types, constants and helpers shared by the escaped delimiter scanner
// depends on nothing

package eds_pkg;

  localparam int CU_W  = 16;  // code unit width
  localparam int LIM_W = 11;  // copy limit register width
  localparam int CNT_W = 12;  // copied / dropped counters and scanned length
  localparam int IDX_W = 3;   // configuration register index width

  localparam int LIM_MAX = 2 ** LIM_W - 1;

  localparam logic [CU_W-1:0]  BACKSLASH     = 16'h005C;
  localparam logic [LIM_W-1:0] LIMIT_RESET   = 11'd1024;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  typedef enum logic [IDX_W-1:0] {
    REG_DELIM_A = 3'd0,
    REG_DELIM_B = 3'd1,
    REG_DELIM_C = 3'd2,
    REG_DELIM_D = 3'd3,
    REG_LIMIT   = 3'd4,
    REG_DROP    = 3'd5
  } reg_idx_e;

  typedef enum logic [1:0] {
    CAUSE_DELIM = 2'd0,
    CAUSE_LIMIT = 2'd1,
    CAUSE_EOS   = 2'd2
  } stop_cause_e;

  typedef struct packed {
    logic [3:0][CU_W-1:0] delim;
    logic [LIM_W-1:0]     copy_limit;
    logic                 drop_escapes;
  } cfg_t;

  typedef struct packed {
    logic [CU_W-1:0]  out_char;
    logic             char_valid;
    logic             scan_done;
    logic [CNT_W-1:0] scanned_length;
    stop_cause_e      stop_cause;
  } result_t;

  // one queue entry: one or two results caused by a single item
  typedef struct packed {
    logic    two;
    result_t r0;
    result_t r1;
  } entry_t;

  function automatic result_t mk_char(input logic [CU_W-1:0] c);
    result_t r;
    r                = '0;
    r.out_char       = c;
    r.char_valid     = 1'b1;
    r.stop_cause     = CAUSE_DELIM;
    return r;
  endfunction

  function automatic result_t mk_end(input logic [CNT_W-1:0] len, input stop_cause_e cause);
    result_t r;
    r                = '0;
    r.scan_done      = 1'b1;
    r.scanned_length = len;
    r.stop_cause     = cause;
    return r;
  endfunction

endpackage

@@ rtl/eds_front.sv @@
`timescale 1ns / 1ps
// eds_front: scan state and per-item classification into queue entries
// depends on eds_pkg

module eds_front #(
  parameter int MAX_FIELD   = 1024,
  parameter int DELIM_SLOTS = 4
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     accept,
  input  logic [eds_pkg::CU_W-1:0] code_unit,
  input  logic                     start_scan,
  input  eds_pkg::cfg_t            cfg,
  output logic                     wr_en,
  output eds_pkg::entry_t          wr_entry
);

  localparam int LIM_CAP = (MAX_FIELD < eds_pkg::LIM_MAX) ? MAX_FIELD : eds_pkg::LIM_MAX;

  logic                      active_r, active_nxt;
  logic                      esc_r, esc_nxt;
  logic [eds_pkg::CNT_W-1:0] copied_r, copied_nxt;
  logic [eds_pkg::CNT_W-1:0] dropped_r, dropped_nxt;

  logic [eds_pkg::LIM_W-1:0] lim;
  logic [eds_pkg::CNT_W-1:0] lim_ext;
  logic                      is_delim;

  assign lim = (cfg.copy_limit > eds_pkg::LIM_W'(LIM_CAP)) ?
               eds_pkg::LIM_W'(LIM_CAP) : cfg.copy_limit;
  assign lim_ext = {1'b0, lim};

  always_comb begin
    is_delim = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (i < DELIM_SLOTS && cfg.delim[i] != '0 && cfg.delim[i] == code_unit) begin
        is_delim = 1'b1;
      end
    end
  end

  always_comb begin
    logic                      act;
    logic                      esc;
    logic [eds_pkg::CNT_W-1:0] cc;
    logic [eds_pkg::CNT_W-1:0] dr;
    logic                      copied_any;
    act         = start_scan | active_r;
    esc         = start_scan ? 1'b0 : esc_r;
    cc          = start_scan ? '0 : copied_r;
    dr          = start_scan ? '0 : dropped_r;
    copied_any  = 1'b0;
    active_nxt  = active_r;
    esc_nxt     = esc_r;
    copied_nxt  = copied_r;
    dropped_nxt = dropped_r;
    wr_en       = 1'b0;
    wr_entry    = '0;
    if (accept) begin
      active_nxt  = act;
      esc_nxt     = esc;
      copied_nxt  = cc;
      dropped_nxt = dr;
      if (act) begin
        if (cc >= lim_ext) begin
          wr_en       = 1'b1;
          wr_entry.r0 = eds_pkg::mk_end(eds_pkg::CNT_W'(cc + dr), eds_pkg::CAUSE_LIMIT);
          active_nxt  = 1'b0;
          esc_nxt     = 1'b0;
        end else if (code_unit == '0) begin
          wr_en       = 1'b1;
          wr_entry.r0 = eds_pkg::mk_end(eds_pkg::CNT_W'(cc + dr), eds_pkg::CAUSE_EOS);
          active_nxt  = 1'b0;
          esc_nxt     = 1'b0;
        end else if (esc) begin
          wr_en      = 1'b1;
          copied_any = 1'b1;
          esc_nxt    = 1'b0;
          if (cfg.drop_escapes) begin
            dropped_nxt = eds_pkg::CNT_W'(dr + 1'b1);
            copied_nxt  = eds_pkg::CNT_W'(cc + 1'b1);
            wr_entry.r0 = eds_pkg::mk_char(code_unit);
          end else begin
            copied_nxt   = eds_pkg::CNT_W'(cc + 2'd2);
            wr_entry.two = 1'b1;
            wr_entry.r0  = eds_pkg::mk_char(eds_pkg::BACKSLASH);
            wr_entry.r1  = eds_pkg::mk_char(code_unit);
          end
        end else if (code_unit == eds_pkg::BACKSLASH) begin
          esc_nxt = 1'b1;
        end else if (is_delim) begin
          wr_en       = 1'b1;
          wr_entry.r0 = eds_pkg::mk_end(eds_pkg::CNT_W'(cc + dr), eds_pkg::CAUSE_DELIM);
          active_nxt  = 1'b0;
          esc_nxt     = 1'b0;
        end else begin
          wr_en       = 1'b1;
          copied_any  = 1'b1;
          copied_nxt  = eds_pkg::CNT_W'(cc + 1'b1);
          wr_entry.r0 = eds_pkg::mk_char(code_unit);
        end
        // limit reached by this copy: the last copied character ends the scan
        if (copied_any && copied_nxt >= lim_ext) begin
          active_nxt = 1'b0;
          esc_nxt    = 1'b0;
          if (wr_entry.two) begin
            wr_entry.r1.scan_done      = 1'b1;
            wr_entry.r1.scanned_length = eds_pkg::CNT_W'(copied_nxt + dropped_nxt);
            wr_entry.r1.stop_cause     = eds_pkg::CAUSE_LIMIT;
          end else begin
            wr_entry.r0.scan_done      = 1'b1;
            wr_entry.r0.scanned_length = eds_pkg::CNT_W'(copied_nxt + dropped_nxt);
            wr_entry.r0.stop_cause     = eds_pkg::CAUSE_LIMIT;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= 1'b0;
      esc_r     <= 1'b0;
      copied_r  <= '0;
      dropped_r <= '0;
    end else begin
      active_r  <= active_nxt;
      esc_r     <= esc_nxt;
      copied_r  <= copied_nxt;
      dropped_r <= dropped_nxt;
    end
  end

endmodule

@@ rtl/eds_queue.sv @@
`timescale 1ns / 1ps
// eds_queue: short entry queue between the front and back parts
// depends on eds_pkg

module eds_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  eds_pkg::entry_t wr_entry,
  input  logic            rd_en,
  output eds_pkg::entry_t rd_entry,
  output logic            q_full,
  output logic            q_empty
);

  eds_pkg::entry_t               mem_r [eds_pkg::Q_DEPTH];
  logic [eds_pkg::Q_AW-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [eds_pkg::Q_AW-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [eds_pkg::Q_AW:0]        count_r, count_nxt;

  assign q_full   = (count_r == (eds_pkg::Q_AW + 1)'(eds_pkg::Q_DEPTH));
  assign q_empty  = (count_r == '0);
  assign rd_entry = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == eds_pkg::Q_AW'(eds_pkg::Q_DEPTH - 1)) ?
                   '0 : eds_pkg::Q_AW'(wr_ptr_r + 1'b1);
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == eds_pkg::Q_AW'(eds_pkg::Q_DEPTH - 1)) ?
                   '0 : eds_pkg::Q_AW'(rd_ptr_r + 1'b1);
    end
    case ({wr_en, rd_en})
      2'b10:   count_nxt = (eds_pkg::Q_AW + 1)'(count_r + 1'b1);
      2'b01:   count_nxt = (eds_pkg::Q_AW + 1)'(count_r - 1'b1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

@@ rtl/eds_back.sv @@
`timescale 1ns / 1ps
// eds_back: splits queue entries into single results for the output port
// depends on eds_pkg

module eds_back (
  input  logic            clk,
  input  logic            rst_n,
  input  eds_pkg::entry_t head,
  input  logic            head_valid,
  input  logic            pop,
  output logic            head_rd,
  output logic            res_valid,
  output eds_pkg::result_t res
);

  logic sub_r, sub_nxt;
  logic taken;

  assign res_valid = head_valid;
  assign res       = sub_r ? head.r1 : head.r0;
  assign taken     = pop & head_valid;

  always_comb begin
    head_rd = 1'b0;
    sub_nxt = sub_r;
    if (taken) begin
      if (head.two && !sub_r) begin
        sub_nxt = 1'b1;
      end else begin
        sub_nxt = 1'b0;
        head_rd = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_r <= 1'b0;
    end else begin
      sub_r <= sub_nxt;
    end
  end

endmodule

@@ rtl/escaped_delimiter_scanner.sv @@
`timescale 1ns / 1ps
// escaped_delimiter_scanner: top level, config registers and the front/queue/back split
// depends on eds_pkg, eds_front, eds_queue, eds_back
//
//   channel   ports                                    handshake
//   input     in_code_unit, in_start_scan              push / full
//   result    out_char, out_char_valid, out_scan_done, empty / pop
//             out_scanned_length, out_stop_cause
//   config    cfg_index, cfg_data                      cfg_valid / cfg_ready
//
// one item is taken per cycle while the queue has room; its results, if any, are
// written into a queue entry and reach the result ports behind any older entries
// the result port moves one result per cycle while pop is high, so an escaped pair
// in keep mode (two results) takes two pops from one entry; the four-entry queue absorbs that
// full rises only when the queue holds four entries; stalls on either side hold
// everything else; reset is synchronous, active low, with no clearing pass

module escaped_delimiter_scanner #(
  parameter int MAX_FIELD   = 1024,
  parameter int DELIM_SLOTS = 4
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // input channel
  input  logic                      push,
  output logic                      full,
  input  logic [eds_pkg::CU_W-1:0]  in_code_unit,
  input  logic                      in_start_scan,
  // result channel
  output logic                      empty,
  input  logic                      pop,
  output logic [eds_pkg::CU_W-1:0]  out_char,
  output logic                      out_char_valid,
  output logic                      out_scan_done,
  output logic [eds_pkg::CNT_W-1:0] out_scanned_length,
  output logic [1:0]                out_stop_cause,
  // configuration channel
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [eds_pkg::IDX_W-1:0] cfg_index,
  input  logic [eds_pkg::CU_W-1:0]  cfg_data
);

  eds_pkg::cfg_t    cfg_r, cfg_nxt;
  logic             accept;
  logic             wr_en;
  eds_pkg::entry_t  wr_entry;
  eds_pkg::entry_t  head;
  logic             q_full;
  logic             q_empty;
  logic             head_rd;
  logic             res_valid;
  eds_pkg::result_t res;

  // config writes are always taken; unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (eds_pkg::reg_idx_e'(cfg_index))
        eds_pkg::REG_DELIM_A: cfg_nxt.delim[0]     = cfg_data;
        eds_pkg::REG_DELIM_B: cfg_nxt.delim[1]     = cfg_data;
        eds_pkg::REG_DELIM_C: cfg_nxt.delim[2]     = cfg_data;
        eds_pkg::REG_DELIM_D: cfg_nxt.delim[3]     = cfg_data;
        eds_pkg::REG_LIMIT:   cfg_nxt.copy_limit   = cfg_data[eds_pkg::LIM_W-1:0];
        eds_pkg::REG_DROP:    cfg_nxt.drop_escapes = cfg_data[0];
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.delim        <= '0;
      cfg_r.copy_limit   <= eds_pkg::LIMIT_RESET;
      cfg_r.drop_escapes <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // an item is taken whenever the queue has a free entry
  assign full   = q_full;
  assign accept = push & ~q_full;

  // front: scan flags and counters, one item per cycle while the queue is not full
  eds_front #(
    .MAX_FIELD   (MAX_FIELD),
    .DELIM_SLOTS (DELIM_SLOTS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .code_unit  (in_code_unit),
    .start_scan (in_start_scan),
    .cfg        (cfg_r),
    .wr_en      (wr_en),
    .wr_entry   (wr_entry)
  );

  // queue of result groups between front and back
  eds_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (wr_en),
    .wr_entry (wr_entry),
    .rd_en    (head_rd),
    .rd_entry (head),
    .q_full   (q_full),
    .q_empty  (q_empty)
  );

  // back: hands out one result of the head entry per pop
  eds_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (~q_empty),
    .pop        (pop),
    .head_rd    (head_rd),
    .res_valid  (res_valid),
    .res        (res)
  );

  assign empty              = ~res_valid;
  assign out_char           = res.out_char;
  assign out_char_valid     = res.char_valid;
  assign out_scan_done      = res.scan_done;
  assign out_scanned_length = res.scanned_length;
  assign out_stop_cause     = res.stop_cause;

endmodule

@@ dv/tb_escaped_delimiter_scanner.sv @@
`timescale 1ns / 1ps
// tb_escaped_delimiter_scanner: self-checking bench for the escaped delimiter scanner
// predicts every result item of each scanned field and checks them in order on the result ports
// depends on eds_pkg and escaped_delimiter_scanner

module tb_escaped_delimiter_scanner;

  localparam int MAX_FIELD     = 1024;
  localparam int DELIM_SLOTS   = 4;
  localparam int STALL_LIMIT   = 2000;  // cycles with no handshake at all
  localparam int SETTLE_CYCLES = 6;     // settling margin after the last owed result is out

  logic                      clk;
  logic                      rst_n;
  logic                      push;
  logic                      full;
  logic [eds_pkg::CU_W-1:0]  in_code_unit;
  logic                      in_start_scan;
  logic                      empty;
  logic                      pop;
  logic [eds_pkg::CU_W-1:0]  out_char;
  logic                      out_char_valid;
  logic                      out_scan_done;
  logic [eds_pkg::CNT_W-1:0] out_scanned_length;
  logic [1:0]                out_stop_cause;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [eds_pkg::IDX_W-1:0] cfg_index;
  logic [eds_pkg::CU_W-1:0]  cfg_data;

  escaped_delimiter_scanner #(
    .MAX_FIELD   (MAX_FIELD),
    .DELIM_SLOTS (DELIM_SLOTS)
  ) DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .push               (push),
    .full               (full),
    .in_code_unit       (in_code_unit),
    .in_start_scan      (in_start_scan),
    .empty              (empty),
    .pop                (pop),
    .out_char           (out_char),
    .out_char_valid     (out_char_valid),
    .out_scan_done      (out_scan_done),
    .out_scanned_length (out_scanned_length),
    .out_stop_cause     (out_stop_cause),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  // shadow of the configuration registers, reset values
  logic [eds_pkg::CU_W-1:0]  delim_sh [4] = '{default: '0};
  logic [eds_pkg::LIM_W-1:0] limit_sh     = eds_pkg::LIMIT_RESET;
  logic                      drop_sh      = 1'b0;

  // scanner state as the predictor sees it
  bit scanning    = 1'b0;
  bit esc_pending = 1'b0;
  int copied_cnt  = 0;
  int dropped_cnt = 0;

  // results still owed by the block, oldest first
  eds_pkg::result_t results_due [$];

  int in_idle_pct  = 0;
  int out_idle_pct = 0;
  int scan_items   = 0;  // items sent
  int checked      = 0;
  int n_fail       = 0;
  int ends_delim   = 0;
  int ends_limit   = 0;
  int ends_eos     = 0;
  int stall_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // receiver: random stalls on pop, driven on the falling edge
  always @(negedge clk) begin
    pop <= ($urandom_range(0, 99) >= out_idle_pct);
  end

  // expected results of one accepted item
  function automatic void scan_predict(input logic [eds_pkg::CU_W-1:0] cu, input logic st);
    eds_pkg::result_t     res [2];
    int                   n;
    int                   lim;
    bit                   done;
    bit                   copied_now;
    bit                   hit;
    eds_pkg::stop_cause_e cause;
    res[0]     = '0;
    res[1]     = '0;
    n          = 0;
    done       = 1'b0;
    copied_now = 1'b0;
    hit        = 1'b0;
    cause      = eds_pkg::CAUSE_DELIM;
    lim        = (int'(limit_sh) < MAX_FIELD) ? int'(limit_sh) : MAX_FIELD;
    // zero slots are unused
    for (int i = 0; i < DELIM_SLOTS; i++)
      if (delim_sh[i] != '0 && delim_sh[i] == cu) hit = 1'b1;

    if (st) begin
      scanning    = 1'b1;
      esc_pending = 1'b0;
      copied_cnt  = 0;
      dropped_cnt = 0;
    end
    if (!scanning) return;  // idle input is ignored

    if (copied_cnt >= lim) begin
      // limit already met on arrival: the item is not consumed
      done  = 1'b1;
      cause = eds_pkg::CAUSE_LIMIT;
      n     = 1;
    end else if (cu == '0) begin
      // end of source, a pending backslash is lost
      done  = 1'b1;
      cause = eds_pkg::CAUSE_EOS;
      n     = 1;
    end else if (esc_pending) begin
      // protected character, delimiters and backslashes included
      if (drop_sh) begin
        dropped_cnt++;
      end else begin
        res[n].out_char   = eds_pkg::BACKSLASH;
        res[n].char_valid = 1'b1;
        n++;
        copied_cnt++;
      end
      res[n].out_char   = cu;
      res[n].char_valid = 1'b1;
      n++;
      copied_cnt++;
      esc_pending = 1'b0;
      copied_now  = 1'b1;
    end else if (cu == eds_pkg::BACKSLASH) begin
      esc_pending = 1'b1;
    end else if (hit) begin
      done  = 1'b1;
      cause = eds_pkg::CAUSE_DELIM;
      n     = 1;
    end else begin
      res[0].out_char   = cu;
      res[0].char_valid = 1'b1;
      n = 1;
      copied_cnt++;
      copied_now = 1'b1;
    end

    // a keep-mode pair may overshoot the limit by one
    if (copied_now && copied_cnt >= lim) begin
      done  = 1'b1;
      cause = eds_pkg::CAUSE_LIMIT;
    end
    if (done) begin
      res[n-1].scan_done      = 1'b1;
      res[n-1].scanned_length = eds_pkg::CNT_W'(copied_cnt + dropped_cnt);
      res[n-1].stop_cause     = cause;
      scanning    = 1'b0;
      esc_pending = 1'b0;
    end
    for (int k = 0; k < n; k++) results_due.push_back(res[k]);
  endfunction

  // result checker: compare every popped item with the oldest expectation
  always @(posedge clk) begin : check_results
    eds_pkg::result_t want;
    if (rst_n && pop && !empty) begin
      if (results_due.size() == 0) begin
        $error("unexpected result item: char %h valid %b done %b len %0d cause %0d",
               out_char, out_char_valid, out_scan_done, out_scanned_length, out_stop_cause);
        n_fail++;
      end else begin
        want = results_due.pop_front();
        checked++;
        if (out_char !== want.out_char) begin
          $error("out_char: expected %h, got %h", want.out_char, out_char);
          n_fail++;
        end
        if (out_char_valid !== want.char_valid) begin
          $error("out_char_valid: expected %b, got %b", want.char_valid, out_char_valid);
          n_fail++;
        end
        if (out_scan_done !== want.scan_done) begin
          $error("out_scan_done: expected %b, got %b", want.scan_done, out_scan_done);
          n_fail++;
        end
        if (out_scanned_length !== want.scanned_length) begin
          $error("out_scanned_length: expected %0d, got %0d",
                 want.scanned_length, out_scanned_length);
          n_fail++;
        end
        if (out_stop_cause !== want.stop_cause) begin
          $error("out_stop_cause: expected %0d, got %0d", want.stop_cause, out_stop_cause);
          n_fail++;
        end
        if (want.scan_done) begin
          case (want.stop_cause)
            eds_pkg::CAUSE_DELIM: ends_delim++;
            eds_pkg::CAUSE_LIMIT: ends_limit++;
            default:              ends_eos++;
          endcase
        end
      end
    end
  end

  // watchdog: no handshake of any kind for too long ends the run
  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("no handshake for %0d cycles, %0d results outstanding",
               stall_cycles, results_due.size());
      $display("tb_escaped_delimiter_scanner NOT OK");
      $finish;
    end
  end

  // sender: one item through push/full, with random idle gaps in front
  // called and returning just after a falling edge, push left high
  task automatic send_item(input logic [eds_pkg::CU_W-1:0] cu, input logic st);
    if ($urandom_range(0, 99) < in_idle_pct) begin
      push <= 1'b0;
      do @(negedge clk); while ($urandom_range(0, 99) < in_idle_pct);
    end
    push          <= 1'b1;
    in_code_unit  <= cu;
    in_start_scan <= st;
    @(posedge clk);
    while (full) @(posedge clk);
    scan_items++;
    scan_predict(cu, st);
    @(negedge clk);
  endtask

  // hold the sender until every owed result is out, then let the pipe settle
  task automatic wait_drained();
    push <= 1'b0;
    while (results_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input eds_pkg::reg_idx_e idx,
                           input logic [eds_pkg::CU_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      eds_pkg::REG_DELIM_A: delim_sh[0] = value;
      eds_pkg::REG_DELIM_B: delim_sh[1] = value;
      eds_pkg::REG_DELIM_C: delim_sh[2] = value;
      eds_pkg::REG_DELIM_D: delim_sh[3] = value;
      eds_pkg::REG_LIMIT:   limit_sh    = value[eds_pkg::LIM_W-1:0];
      eds_pkg::REG_DROP:    drop_sh     = value[0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // full register set; only called with the block drained
  task automatic set_config(input logic [eds_pkg::CU_W-1:0] d_a,
                            input logic [eds_pkg::CU_W-1:0] d_b,
                            input logic [eds_pkg::CU_W-1:0] d_c,
                            input logic [eds_pkg::CU_W-1:0] d_d,
                            input int lim, input bit drop);
    write_reg(eds_pkg::REG_DELIM_A, d_a);
    write_reg(eds_pkg::REG_DELIM_B, d_b);
    write_reg(eds_pkg::REG_DELIM_C, d_c);
    write_reg(eds_pkg::REG_DELIM_D, d_d);
    write_reg(eds_pkg::REG_LIMIT, eds_pkg::CU_W'(lim));
    write_reg(eds_pkg::REG_DROP, eds_pkg::CU_W'(drop));
    cfg_valid <= 1'b0;
  endtask

  // any code unit, biased toward the interesting ones
  function automatic logic [eds_pkg::CU_W-1:0] pick_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return eds_pkg::CU_W'($urandom);
    if (r < 65) return eds_pkg::CU_W'($urandom_range(32, 126));
    if (r < 80) return delim_sh[$urandom_range(0, 3)];
    if (r < 94) return eds_pkg::BACKSLASH;
    return '0;
  endfunction

  // ordinary field content: never a terminator or an escape
  function automatic logic [eds_pkg::CU_W-1:0] pick_plain();
    logic [eds_pkg::CU_W-1:0] c;
    do begin
      c = $urandom_range(0, 1) ? eds_pkg::CU_W'($urandom) :
                                 eds_pkg::CU_W'($urandom_range(32, 126));
    end while (c == '0 || c == eds_pkg::BACKSLASH || c == delim_sh[0] || c == delim_sh[1] ||
               c == delim_sh[2] || c == delim_sh[3]);
    return c;
  endfunction

  // mostly well-formed fields with random content, some noise and cut-off fields
  task automatic run_fields(input int n_items);
    int stop_at;
    int r;
    stop_at = scan_items + n_items;
    while (scan_items < stop_at) begin
      if ($urandom_range(0, 9) == 0) begin
        send_item(pick_char(), 1'($urandom_range(0, 1)));
      end else begin
        send_item(($urandom_range(0, 3) == 0) ? pick_char() : pick_plain(), 1'b1);
        repeat ($urandom_range(0, 10)) begin
          if ($urandom_range(0, 4) == 0) begin
            send_item(eds_pkg::BACKSLASH, 1'b0);
            send_item(pick_char(), 1'b0);
          end else begin
            send_item(pick_plain(), 1'b0);
          end
        end
        r = $urandom_range(0, 19);
        if (r < 12)
          send_item(delim_sh[$urandom_range(0, 3)], 1'b0);
        else if (r < 17)
          send_item('0, 1'b0);
        // otherwise the next start cuts the field off
      end
    end
  endtask

  // keep mode: protected delimiter and backslash, extreme code units,
  // ignored idle item, pending backslash at end of source, empty field
  task automatic test_keep_escapes();
    set_config(16'h002C, 16'h003B, 16'hFFFF, 16'h0001, int'(eds_pkg::LIMIT_RESET), 1'b0);
    send_item(16'h0041, 1'b1);
    send_item(eds_pkg::BACKSLASH, 1'b0);
    send_item(16'h002C, 1'b0);
    send_item(eds_pkg::BACKSLASH, 1'b0);
    send_item(eds_pkg::BACKSLASH, 1'b0);
    send_item(16'h8000, 1'b0);
    send_item(16'hFFFF, 1'b0);
    send_item(16'h7FFF, 1'b0);
    send_item(16'h0078, 1'b1);
    send_item(eds_pkg::BACKSLASH, 1'b0);
    send_item(16'h0000, 1'b0);
    send_item(16'h0000, 1'b1);
  endtask

  // drop mode: escapes removed but counted in the scanned length
  task automatic test_drop_escapes();
    wait_drained();
    set_config(16'h002C, 16'h003B, 16'hFFFF, 16'h0001, int'(eds_pkg::LIMIT_RESET), 1'b1);
    send_item(eds_pkg::BACKSLASH, 1'b1);
    send_item(16'h0001, 1'b0);
    send_item(16'h0062, 1'b0);
    send_item(eds_pkg::BACKSLASH, 1'b0);
    send_item(eds_pkg::BACKSLASH, 1'b0);
    send_item(16'h003B, 1'b0);
  endtask

  // copy limit: keep-mode pair overshoot, zero limit, limit lowered mid-scan
  task automatic test_copy_limit();
    wait_drained();
    set_config(16'h002C, 16'h003B, 16'h0000, 16'h0000, 2, 1'b0);
    send_item(16'h0061, 1'b1);
    send_item(eds_pkg::BACKSLASH, 1'b0);
    send_item(16'h0078, 1'b0);
    wait_drained();
    set_config(16'h002C, 16'h003B, 16'h0000, 16'h0000, 0, 1'b1);
    send_item(16'h0071, 1'b1);
    wait_drained();
    set_config(16'h002C, 16'h003B, 16'h0000, 16'h0000, int'(eds_pkg::LIMIT_RESET), 1'b0);
    send_item(16'h0061, 1'b1);
    send_item(16'h0062, 1'b0);
    // scan still open, block drained: shrink the limit under it
    wait_drained();
    set_config(16'h002C, 16'h003B, 16'h0000, 16'h0000, 1, 1'b0);
    send_item(16'h0063, 1'b0);
  endtask

  // keep mode, tight limits, sender lightly idle and receiver often stalled
  task automatic test_random_keep();
    wait_drained();
    in_idle_pct  = 22;
    out_idle_pct = 49;
    set_config(eds_pkg::CU_W'($urandom_range(32, 126)), eds_pkg::CU_W'($urandom_range(32, 126)),
               eds_pkg::CU_W'($urandom_range(32, 126)), 16'h0000, $urandom_range(1, 6), 1'b0);
    run_fields(230);
  endtask

  // drop mode, extreme delimiters, default limit, stall pattern swapped
  task automatic test_random_drop();
    wait_drained();
    in_idle_pct  = 49;
    out_idle_pct = 22;
    set_config(16'hFFFF, 16'h0001, eds_pkg::CU_W'($urandom_range(32, 126)), 16'h0000,
               int'(eds_pkg::LIMIT_RESET), 1'b1);
    run_fields(230);
  endtask

  // back to back on both sides, several settings including a zero limit
  task automatic test_random_streaming();
    wait_drained();
    in_idle_pct  = 0;
    out_idle_pct = 0;
    set_config(eds_pkg::CU_W'($urandom), eds_pkg::CU_W'($urandom_range(32, 126)),
               eds_pkg::CU_W'($urandom_range(32, 126)), eds_pkg::CU_W'($urandom_range(32, 126)),
               $urandom_range(1, 16), 1'($urandom_range(0, 1)));
    run_fields(200);
    wait_drained();
    set_config(16'h002C, 16'h0000, 16'h0000, 16'h0000, 0, 1'b1);
    run_fields(20);
    wait_drained();
    set_config(16'h002C, 16'h003B, 16'h0020, 16'h007C, int'(eds_pkg::LIMIT_RESET), 1'b0);
    run_fields(40);
  endtask

  initial begin
    rst_n         = 1'b0;
    push          = 1'b0;
    pop           = 1'b0;
    in_code_unit  = '0;
    in_start_scan = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = eds_pkg::REG_DELIM_A;
    cfg_data      = '0;
    in_idle_pct   = 22;
    out_idle_pct  = 49;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    test_keep_escapes();
    test_drop_escapes();
    test_copy_limit();
    test_random_keep();
    test_random_drop();
    test_random_streaming();
    wait_drained();

    $display("sent %0d input items in keep and drop modes, checked %0d result items",
             scan_items, checked);
    $display("fields ended by delimiter %0d, copy limit %0d, end of source %0d",
             ends_delim, ends_limit, ends_eos);
    if (n_fail == 0)
      $display("tb_escaped_delimiter_scanner OK");
    else
      $display("tb_escaped_delimiter_scanner NOT OK");
    $finish;
  end

endmodule
